>>> hdl/sha1_message_digest_assert.svh
// assertion macros used by the checker file
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// property that must hold in the same cycle
`define SHA1MD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sha1 digest assertion failed");

// property that must hold in the cycle after a trigger
`define SHA1MD_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sha1 digest assertion failed");

`endif

>>> hdl/sha1md_pkg.sv
// shared types and constants of the sha-1 digest engine
`default_nettype none
package sha1md_pkg;

  // word passed from the packer to the compression engine
  typedef struct packed {
    logic [31:0] word;
    logic        fin;
  } qent_t;

  // initial chaining values, index 0 is h0
  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // round constants
  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [3:0] LEN_WORD_POS = 4'd14;
  localparam logic [2:0] LAST_DIGEST_IDX = 3'd4;

endpackage
`default_nettype wire

>>> hdl/sha1md_front.sv
// byte packer and padding sequencer
`default_nettype none
module sha1md_front
  import sha1md_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  valid_bytes_i,
  input  wire logic        last_word_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output qent_t            q_entry_o
);

  typedef enum logic [2:0] {F_IDLE, F_PAD, F_ZERO, F_LHI, F_LLO} fstate_e;

  fstate_e     state_q, state_d;
  logic [23:0] acc_q, acc_d;
  logic [1:0]  acc_cnt_q, acc_cnt_d;
  logic [3:0]  wpos_q, wpos_d;
  logic [60:0] bytes_q, bytes_d;

  logic [2:0]  cnt;
  logic [31:0] mask;
  logic [55:0] comb;
  logic [2:0]  sum;
  logic        accept;
  logic [63:0] bit_len;

  // clamp the byte count and keep only the valid bytes
  always_comb begin
    cnt = (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;
    case (cnt)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'hFF00_0000;
      3'd2:    mask = 32'hFFFF_0000;
      3'd3:    mask = 32'hFFFF_FF00;
      default: mask = 32'hFFFF_FFFF;
    endcase
    comb = {acc_q, 32'h0} | ({data_word_i & mask, 24'h0} >> {acc_cnt_q, 3'b000});
    sum  = {1'b0, acc_cnt_q} + cnt;
  end

  assign full_o  = (state_q != F_IDLE) || q_full_i;
  assign accept  = push_i && !full_o;
  assign bit_len = {bytes_q, 3'b000};

  // sequencer: pack data, then pad byte, zero words and length
  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    acc_cnt_d = acc_cnt_q;
    bytes_d   = bytes_q;
    q_push_o  = 1'b0;
    q_entry_o = '{word: 32'h0, fin: 1'b0};
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          bytes_d = bytes_q + {58'h0, cnt};
          if (sum >= 3'd4) begin
            q_push_o       = 1'b1;
            q_entry_o.word = comb[55:24];
            acc_d          = comb[23:0];
            acc_cnt_d      = 2'(sum - 3'd4);
          end else begin
            acc_d     = comb[55:32];
            acc_cnt_d = sum[1:0];
          end
          if (last_word_i) state_d = F_PAD;
        end
      end
      F_PAD: begin
        if (!q_full_i) begin
          q_push_o       = 1'b1;
          q_entry_o.word = {acc_q, 8'h00} | ({PAD_BYTE, 24'h0} >> {acc_cnt_q, 3'b000});
          acc_d          = 24'h0;
          acc_cnt_d      = 2'd0;
          state_d        = F_ZERO;
        end
      end
      F_ZERO: begin
        if (wpos_q == LEN_WORD_POS) begin
          state_d = F_LHI;
        end else if (!q_full_i) begin
          q_push_o = 1'b1;
        end
      end
      F_LHI: begin
        if (!q_full_i) begin
          q_push_o       = 1'b1;
          q_entry_o.word = bit_len[63:32];
          state_d        = F_LLO;
        end
      end
      F_LLO: begin
        if (!q_full_i) begin
          q_push_o       = 1'b1;
          q_entry_o.word = bit_len[31:0];
          q_entry_o.fin  = 1'b1;
          bytes_d        = 61'h0;
          state_d        = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
    wpos_d = q_push_o ? wpos_q + 4'd1 : wpos_q;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      acc_q     <= 24'h0;
      acc_cnt_q <= 2'd0;
      wpos_q    <= 4'd0;
      bytes_q   <= 61'h0;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      acc_cnt_q <= acc_cnt_d;
      wpos_q    <= wpos_d;
      bytes_q   <= bytes_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/sha1md_queue.sv
// short word queue between packer and compression engine
`default_nettype none
module sha1md_queue
  import sha1md_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire qent_t entry_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output qent_t      entry_o,
  output logic       empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  qent_t         mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
      if (do_pop)  rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule
`default_nettype wire

>>> hdl/sha1md_back.sv
// 80-round compression engine and digest output
`default_nettype none
module sha1md_back
  import sha1md_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire qent_t       q_entry_i,
  input  wire logic        q_empty_i,
  output logic             q_pop_o,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_result_o
);

  typedef enum logic [1:0] {B_LOAD, B_ROUND, B_ADD, B_OUT} bstate_e;

  bstate_e     state_q;
  logic [31:0] w_q [16];
  logic [31:0] h_q [5];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [3:0]  ld_cnt_q;
  logic [6:0]  rnd_q;
  logic        fin_q;
  logic [2:0]  idx_q;

  logic [31:0] f, k, t, w_next, x;

  // round function, constant and schedule word
  always_comb begin
    if (rnd_q inside {[7'd0:7'd19]}) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K_0;
    end else if (rnd_q inside {[7'd20:7'd39]}) begin
      f = b_q ^ c_q ^ d_q;
      k = K_1;
    end else if (rnd_q inside {[7'd40:7'd59]}) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K_2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K_3;
    end
    t      = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
    x      = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_next = {x[30:0], x[31]};
  end

  assign q_pop_o       = (state_q == B_LOAD) && !q_empty_i;
  assign empty_o       = (state_q != B_OUT);
  assign digest_word_o = h_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_result_o = (idx_q == LAST_DIGEST_IDX);

  // message schedule window
  always_ff @(posedge clk_i) begin
    if (q_pop_o || state_q == B_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= q_pop_o ? q_entry_i.word : w_next;
    end
  end

  // sequencer, working variables and chaining values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_LOAD;
      ld_cnt_q <= 4'd0;
      rnd_q    <= 7'd0;
      fin_q    <= 1'b0;
      idx_q    <= 3'd0;
      a_q      <= 32'h0;
      b_q      <= 32'h0;
      c_q      <= 32'h0;
      d_q      <= 32'h0;
      e_q      <= 32'h0;
      for (int i = 0; i < 5; i++) h_q[i] <= H_INIT[i];
    end else begin
      case (state_q)
        B_LOAD: begin
          if (q_pop_o) begin
            ld_cnt_q <= ld_cnt_q + 4'd1;
            if (ld_cnt_q == 4'd15) begin
              fin_q   <= q_entry_i.fin;
              rnd_q   <= 7'd0;
              a_q     <= h_q[0];
              b_q     <= h_q[1];
              c_q     <= h_q[2];
              d_q     <= h_q[3];
              e_q     <= h_q[4];
              state_q <= B_ROUND;
            end
          end
        end
        B_ROUND: begin
          a_q   <= t;
          b_q   <= a_q;
          c_q   <= {b_q[1:0], b_q[31:2]};
          d_q   <= c_q;
          e_q   <= d_q;
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == 7'd79) state_q <= B_ADD;
        end
        B_ADD: begin
          h_q[0]  <= h_q[0] + a_q;
          h_q[1]  <= h_q[1] + b_q;
          h_q[2]  <= h_q[2] + c_q;
          h_q[3]  <= h_q[3] + d_q;
          h_q[4]  <= h_q[4] + e_q;
          idx_q   <= 3'd0;
          state_q <= fin_q ? B_OUT : B_LOAD;
        end
        B_OUT: begin
          if (pop_i) begin
            if (idx_q == LAST_DIGEST_IDX) begin
              for (int i = 0; i < 5; i++) h_q[i] <= H_INIT[i];
              idx_q   <= 3'd0;
              state_q <= B_LOAD;
            end else begin
              idx_q <= idx_q + 3'd1;
            end
          end
        end
        default: state_q <= B_LOAD;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/sha1_message_digest.sv
// top level of the sha-1 digest engine
//
// Input queue: drive data_word_i, valid_bytes_i and last_word_i with push; a
// transaction happens when push is high and full is low. Bytes are taken from
// the top of the word and packed densely; last_word_i ends the message.
// Result queue: while empty is low the next digest word is shown with its
// word_index_o and last_result_o; a transaction happens when pop is high and
// empty is low. Each message yields five words, h0 first.
// Throughput: the compression unit does one round per cycle; a 64-byte
// block is loaded as 16 words, then 80 rounds and one add follow before the
// next block is taken. After the last word the packer writes padding words
// (up to 18) and then stays full until it is done. The digest is shown in
// the output state that follows the final block's add. A short queue of
// QUEUE_DEPTH words decouples the packer from the compression unit.
// Stall: while the receiver holds off pop the digest waits, the compression
// unit holds and the input queue backs up until full rises.
// Reset: chaining values return to the initial constants, all counts clear.
`default_nettype none
module sha1_message_digest
  import sha1md_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  valid_bytes_i,
  input  wire logic        last_word_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_result_o
);

  qent_t f_entry, b_entry;
  logic  f_push, q_full, q_pop, q_empty;

  // packer and padding
  sha1md_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .data_word_i, .valid_bytes_i, .last_word_i,
    .q_full_i(q_full), .q_push_o(f_push), .q_entry_o(f_entry)
  );

  // word queue
  sha1md_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni, .push_i(f_push), .entry_i(f_entry), .full_o(q_full),
    .pop_i(q_pop), .entry_o(b_entry), .empty_o(q_empty)
  );

  // compression and digest output
  sha1md_back u_back (
    .clk_i, .rst_ni, .q_entry_i(b_entry), .q_empty_i(q_empty), .q_pop_o(q_pop),
    .empty_o(empty), .pop_i(pop), .digest_word_o, .word_index_o, .last_result_o
  );

endmodule
`default_nettype wire

>>> hdl/sha1md_checker.sv
// port-level checker for the sha-1 digest engine and its bind
`default_nettype none
`include "sha1_message_digest_assert.svh"
module sha1md_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [31:0] digest_word_o,
  input wire logic [2:0]  word_index_o,
  input wire logic        last_result_o
);

  // final flag marks exactly the fifth word
  `SHA1MD_ASSERT(a_last_idx, clk_i, rst_ni, empty || (last_result_o == (word_index_o == 3'd4)))
  // index stays within the digest
  `SHA1MD_ASSERT(a_idx_range, clk_i, rst_ni, empty || (word_index_o <= 3'd4))
  // words of one digest follow back to back in order
  `SHA1MD_ASSERT_NEXT(a_idx_step, clk_i, rst_ni, pop && !empty && !last_result_o,
    !empty && (word_index_o == $past(word_index_o) + 3'd1))
  // a waiting word holds
  `SHA1MD_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop,
    !empty && $stable(digest_word_o) && $stable(word_index_o))

endmodule

bind sha1_message_digest sha1md_checker u_checker (
  .clk_i, .rst_ni, .empty, .pop, .digest_word_o, .word_index_o, .last_result_o
);
`default_nettype wire

>>> bench/sha1_message_digest_tb.sv
// testbench for the sha-1 digest engine: directed and random messages checked against a behavioral digest
`timescale 1ns / 1ps
module sha1_message_digest_tb;
  import sha1md_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] data_word_i = '0;
  logic [2:0]  valid_bytes_i = '0;
  logic        last_word_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_result_o;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_t;

  localparam int LIMIT_CYCLES = 600000;

  // digest model state
  logic [31:0] hash_st [5];
  logic [31:0] blk_st [16];
  int unsigned fill_st;
  logic [63:0] len_st;

  digest_t     digest_q [$];
  int          err_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          hold_pop = 1'b0;
  bit          quiet_send = 1'b0;

  sha1_message_digest dut (
    .clk_i, .rst_ni, .push, .full, .data_word_i, .valid_bytes_i, .last_word_i,
    .empty, .pop, .digest_word_o, .word_index_o, .last_result_o
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("[sha1_message_digest] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void hash_restart();
    for (int i = 0; i < 5; i++) hash_st[i] = H_INIT[i];
    fill_st = 0;
    len_st = '0;
  endfunction

  function automatic void compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) w[r] = blk_st[r];
    for (int r = 16; r < 80; r++) w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3]; e = hash_st[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d); k = K_0;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = K_1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K_2;
      end else begin
        f = b ^ c ^ d; k = K_3;
      end
      t = rol(a, 5) + f + e + k + w[r];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d; hash_st[4] += e;
  endfunction

  function automatic void add_byte(logic [7:0] by);
    int unsigned p;
    p = fill_st;
    if (p % 4 == 0) blk_st[p/4] = {by, 24'h0};
    else blk_st[p/4] |= 32'(by) << ((3 - p % 4) * 8);
    fill_st = p + 1;
    if (fill_st == 64) begin
      compress();
      fill_st = 0;
    end
  endfunction

  // expected digest words for one accepted word
  function automatic void digest_absorb(logic [31:0] dw, logic [2:0] nb, logic lst);
    int unsigned cnt;
    logic [63:0] len;
    digest_t dg;
    cnt = (nb > 4) ? 4 : nb;
    for (int i = 0; i < cnt; i++) begin
      add_byte(dw[31 - 8*i -: 8]);
      len_st += 64'd8;
    end
    if (!lst) return;
    len = len_st;
    add_byte(PAD_BYTE);
    while (fill_st != 56) add_byte(8'h00);
    for (int i = 0; i < 8; i++) add_byte(len[63 - 8*i -: 8]);
    for (int i = 0; i < 5; i++) begin
      dg.word = hash_st[i];
      dg.idx = 3'(i);
      dg.fin = (i == LAST_DIGEST_IDX);
      digest_q.push_back(dg);
    end
    hash_restart();
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] exp);
    err_cnt++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
  endtask

  // result checker, sampling at the rising edge
  always @(posedge clk_i) begin
    digest_t dg;
    if (rst_ni && pop && !empty) begin
      if (digest_q.size() == 0) begin
        report("unexpected transaction", digest_word_o, 32'h0);
      end else begin
        dg = digest_q.pop_front();
        if (digest_word_o !== dg.word) report("digest_word", digest_word_o, dg.word);
        if (word_index_o !== dg.idx) report("word_index", 32'(word_index_o), 32'(dg.idx));
        if (last_result_o !== dg.fin) report("last_result", 32'(last_result_o), 32'(dg.fin));
      end
    end
  end

  // receiver stall pattern plus a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_pop) pop <= 1'b0;
    else if (cycle_cnt % 512 < 128) pop <= 1'b1;
    else pop <= ($urandom_range(0, 3) != 0);
  end

  // send one word: bursts with random gaps
  task automatic send_word(logic [31:0] dw, logic [2:0] nb, logic lst);
    int gap;
    gap = quiet_send ? 0 : (($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    data_word_i <= dw;
    valid_bytes_i <= nb;
    last_word_i <= lst;
    do @(posedge clk_i); while (full);
    digest_absorb(dw, nb, lst);
    @(negedge clk_i);
  endtask

  // drop push
  task automatic idle_sender();
    push <= 1'b0;
    @(negedge clk_i);
  endtask

  // message of n full words then a last word with lb bytes
  task automatic send_message(int n, logic [2:0] lb);
    for (int i = 0; i < n; i++) send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, lb, 1'b1);
  endtask

  task automatic test_directed();
    send_word(32'h0, 3'd0, 1'b1);                 // empty message
    send_word(32'h61626300, 3'd3, 1'b1);          // "abc"
    send_word(32'hFFFFFFFF, 3'd4, 1'b1);
    send_word(32'h12345678, 3'd7, 1'b1);          // count above four
    send_word(32'hA5000000, 3'd1, 1'b0);          // short word mid-message
    send_word(32'hBEEF0000, 3'd2, 1'b0);
    send_word(32'hC0FFEE11, 3'd5, 1'b1);
    send_message(13, 3'd3);                       // 55 bytes, one block
    send_message(13, 3'd4);                       // 56 bytes, second block
    idle_sender();
  endtask

  task automatic test_pressure();
    hold_pop = 1'b1;
    quiet_send = 1'b1;
    fork
      begin
        repeat (1500) @(negedge clk_i);
        hold_pop = 1'b0;
      end
      begin
        send_message(3, 3'd4);
        send_message(2, 3'd2);
        send_message(5, 3'd1);
      end
    join
    quiet_send = 1'b0;
    idle_sender();
  endtask

  task automatic test_random();
    int words;
    words = 0;
    while (words < 270) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 15);
      for (int i = 0; i < n; i++)
        send_word($urandom, ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'd4, 1'b0);
      send_word($urandom, 3'($urandom), 1'b1);
      words += n + 1;
    end
    idle_sender();
  endtask

  initial begin
    hash_restart();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_pressure();
    test_random();
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[sha1_message_digest] OK");
    end else begin
      $display("[sha1_message_digest] ERROR");
    end
    $finish;
  end

endmodule
